// ----- rtl/bpt_pkg.sv -----
// types, codes and helpers shared by the breakpoint table converter
// no dependencies
`timescale 1ns / 1ps

package bpt_pkg;

  localparam int TP_W   = 7;   // table_points register width
  localparam int DQ_W   = 49;  // quotient width of the serial divider
  localparam int DR_W   = 33;  // partial remainder width
  localparam int DCNT_W = 6;   // divider step counter width
  localparam int ENT_W  = 96;  // raw, eng and slope of one breakpoint

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_R2E  = 2'd1,
    CMD_E2R  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SLOPE = 2'd2,
    ST_SHORT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_ECHO,
    SEL_R2E,
    SEL_E2R
  } res_sel_t;

  typedef struct packed {
    cmd_t               command;
    logic               restart_search;
    logic signed [31:0] value;
    logic [5:0]         entry_index;
    logic signed [31:0] entry_raw;
    logic signed [31:0] entry_eng;
    logic signed [31:0] entry_slope;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    status_t            status;
  } out_beat_t;

  typedef struct packed {
    logic     cap;
    logic     load_wr;
    logic     start;
    logic     rd_up;
    logic     up_step;
    logic     dn_step;
    logic     take;
    logic     mul;
    logic     div_init;
    logic     div_step;
    logic     out_load;
    logic     save_hint;
    res_sel_t sel;
    status_t  st;
  } ctl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic short_tbl;
    logic up_le;
    logic up_end;
    logic dn_gt;
    logic k_zero;
    logic slope_zero;
    logic div_done;
    logic out_free;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [50:0] x);
    logic signed [50:0] hi;
    logic signed [50:0] lo;
    hi = 51'sh7FFF_FFFF;
    lo = ~51'sh7FFF_FFFF;
    if (x > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

endpackage

// ----- rtl/bpt_ram.sv -----
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module bpt_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/bpt_ctrl.sv -----
// sequencer for load, interval walk, multiply and serial divide
// depends on bpt_pkg
`timescale 1ns / 1ps

module bpt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bpt_pkg::dp_stat_t stat,
  output bpt_pkg::ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP,
    S_MUL, S_DINIT, S_DIV, S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  bpt_pkg::res_sel_t   sel_r, sel_nxt;
  bpt_pkg::status_t    st_r, st_nxt;
  logic                ok_r, ok_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    sel_nxt   = sel_r;
    st_nxt    = st_r;
    ok_nxt    = ok_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_FIN;
        ok_nxt    = 1'b0;
        st_nxt    = bpt_pkg::ST_OK;
        sel_nxt   = bpt_pkg::SEL_ECHO;
        case (stat.cmd)
          bpt_pkg::CMD_LOAD: begin
            cmd.load_wr = 1'b1;
            sel_nxt     = bpt_pkg::SEL_ZERO;
          end
          bpt_pkg::CMD_R2E, bpt_pkg::CMD_E2R: begin
            if (stat.short_tbl) begin
              st_nxt = bpt_pkg::ST_SHORT;
            end else begin
              cmd.start = 1'b1;
              state_nxt = S_UP_RD;
            end
          end
          default: ;
        endcase
      end
      S_UP_RD: begin
        cmd.rd_up = 1'b1;
        state_nxt = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (stat.up_le) begin
          if (stat.up_end) begin
            st_nxt    = bpt_pkg::ST_RANGE;
            state_nxt = S_FIN;
          end else begin
            cmd.up_step = 1'b1;
            state_nxt   = S_UP_RD;
          end
        end else begin
          state_nxt = S_DN_RD;
        end
      end
      S_DN_RD: begin
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat.dn_gt) begin
          if (stat.k_zero) begin
            st_nxt    = bpt_pkg::ST_RANGE;
            state_nxt = S_FIN;
          end else begin
            cmd.dn_step = 1'b1;
            state_nxt   = S_DN_RD;
          end
        end else begin
          cmd.take = 1'b1;
          if (stat.cmd == bpt_pkg::CMD_R2E) begin
            state_nxt = S_MUL;
          end else if (stat.slope_zero) begin
            st_nxt    = bpt_pkg::ST_SLOPE;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_DINIT;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        sel_nxt   = bpt_pkg::SEL_R2E;
        ok_nxt    = 1'b1;
        state_nxt = S_FIN;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          sel_nxt   = bpt_pkg::SEL_E2R;
          ok_nxt    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FIN: begin
        cmd.sel = sel_r;
        cmd.st  = st_r;
        if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.save_hint = ok_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= bpt_pkg::SEL_ZERO;
      st_r    <= bpt_pkg::ST_OK;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      st_r    <= st_nxt;
      ok_r    <= ok_nxt;
    end
  end

endmodule

// ----- rtl/bpt_dp.sv -----
// datapath: breakpoint ram, interval index, multiplier, serial divider, output register
// depends on bpt_pkg and bpt_ram
`timescale 1ns / 1ps

module bpt_dp #(
  parameter int MAX_POINTS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [bpt_pkg::TP_W-1:0] cfg_data,
  input  bpt_pkg::in_beat_t       in_data,
  output bpt_pkg::out_beat_t      out_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  bpt_pkg::ctl_cmd_t       cmd,
  output bpt_pkg::dp_stat_t       stat
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = ((IW > bpt_pkg::TP_W) ? IW : bpt_pkg::TP_W) + 2;
  localparam int QW = bpt_pkg::DQ_W;
  localparam int RW = bpt_pkg::DR_W;

  bpt_pkg::in_beat_t        in_r;
  bpt_pkg::out_beat_t       out_r, out_nxt;
  logic                     out_valid_r;
  logic [bpt_pkg::TP_W-1:0] tp_r;
  logic [IW-1:0]            hint_r, k_r, k_init, raddr;
  logic signed [31:0]       ent_raw_r, ent_eng_r, ent_slope_r;
  logic signed [64:0]       prod_r;
  logic [RW+QW-1:0]         rq_r;
  logic [31:0]              dmag_r;
  logic                     qneg_r;
  logic [bpt_pkg::DCNT_W-1:0] dcnt_r;

  logic [bpt_pkg::TP_W-1:0] n;
  logic [CW-1:0]            n_x, k_x, hint_x;
  logic [bpt_pkg::ENT_W-1:0] rdata;
  logic signed [31:0]       rd_raw, rd_eng, rd_slope, coord;
  logic                     ram_we;

  logic signed [32:0] d_r2e, d_e2r;
  logic signed [48:0] num, sh;
  logic [QW-1:0]      mag;
  logic [RW-1:0]      rem_new, rem_upd;
  logic [RW:0]        diff;
  logic               qbit;
  logic signed [49:0] q50, qs;
  logic signed [50:0] r2e_sum, e2r_sum;

  assign n      = (int'(tp_r) > MAX_POINTS) ? bpt_pkg::TP_W'(MAX_POINTS) : tp_r;
  assign n_x    = CW'(n);
  assign k_x    = CW'(k_r);
  assign hint_x = CW'(hint_r);
  assign k_init = (hint_x + CW'(1) >= n_x) ? IW'(n_x - CW'(2)) : hint_r;
  assign raddr  = cmd.rd_up ? IW'(k_x + CW'(1)) : k_r;
  assign ram_we = cmd.load_wr && (int'(in_r.entry_index) < MAX_POINTS);

  bpt_ram #(.W(bpt_pkg::ENT_W), .D(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IW'(in_r.entry_index)),
    .wdata ({in_r.entry_raw, in_r.entry_eng, in_r.entry_slope}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_raw   = rdata[95:64];
  assign rd_eng   = rdata[63:32];
  assign rd_slope = rdata[31:0];
  assign coord    = (in_r.command == bpt_pkg::CMD_E2R) ? rd_eng : rd_raw;

  always_comb begin
    stat            = '0;
    stat.cmd        = in_r.command;
    stat.short_tbl  = n < bpt_pkg::TP_W'(2);
    stat.up_le      = coord <= in_r.value;
    stat.dn_gt      = coord > in_r.value;
    stat.up_end     = k_x + CW'(2) >= n_x;
    stat.k_zero     = k_r == '0;
    stat.slope_zero = rd_slope == '0;
    stat.div_done   = dcnt_r == bpt_pkg::DCNT_W'(QW);
    stat.out_free   = !out_valid_r || out_ready;
  end

  // arithmetic
  assign d_r2e   = 33'(in_r.value) - 33'(ent_raw_r);
  assign d_e2r   = 33'(in_r.value) - 33'(ent_eng_r);
  assign num     = {d_e2r, 16'b0};
  assign mag     = num[48] ? QW'(-num) : QW'(num);
  assign rem_new = rq_r[RW+QW-2:QW-1];
  assign diff    = {1'b0, rem_new} - {2'b0, dmag_r};
  assign qbit    = !diff[RW];
  assign rem_upd = qbit ? diff[RW-1:0] : rem_new;
  assign sh      = prod_r[64:16];
  assign q50     = {1'b0, rq_r[QW-1:0]};
  assign qs      = qneg_r ? -q50 : q50;
  assign r2e_sum = 51'(sh) + 51'(ent_eng_r);
  assign e2r_sum = 51'(qs) + 51'(ent_raw_r);

  always_comb begin
    out_nxt.status = cmd.st;
    case (cmd.sel)
      bpt_pkg::SEL_ZERO: out_nxt.result_value = '0;
      bpt_pkg::SEL_R2E:  out_nxt.result_value = bpt_pkg::sat32(r2e_sum);
      bpt_pkg::SEL_E2R:  out_nxt.result_value = bpt_pkg::sat32(e2r_sum);
      default:           out_nxt.result_value = in_r.value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_r        <= '0;
      hint_r      <= '0;
      out_valid_r <= 1'b0;
      dcnt_r      <= '0;
    end else begin
      if (cfg_we) begin
        tp_r <= cfg_data;
      end
      if (cmd.cap && in_data.restart_search &&
          (in_data.command == bpt_pkg::CMD_R2E || in_data.command == bpt_pkg::CMD_E2R)) begin
        hint_r <= '0;
      end else if (cmd.save_hint) begin
        hint_r <= k_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.div_init) begin
        dcnt_r <= '0;
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      in_r <= in_data;
    end
    if (cmd.start) begin
      k_r <= k_init;
    end else if (cmd.up_step) begin
      k_r <= k_r + 1'b1;
    end else if (cmd.dn_step) begin
      k_r <= k_r - 1'b1;
    end
    if (cmd.take) begin
      ent_raw_r   <= rd_raw;
      ent_eng_r   <= rd_eng;
      ent_slope_r <= rd_slope;
    end
    if (cmd.mul) begin
      prod_r <= d_r2e * ent_slope_r;
    end
    if (cmd.div_init) begin
      rq_r   <= {{RW{1'b0}}, mag};
      dmag_r <= ent_slope_r[31] ? 32'(-ent_slope_r) : 32'(ent_slope_r);
      qneg_r <= num[48] ^ ent_slope_r[31];
    end else if (cmd.div_step) begin
      rq_r <= {rem_upd, rq_r[QW-2:0], qbit};
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/breakpoint_table_convert.sv -----
// top level of the piecewise linear breakpoint table converter
// depends on bpt_pkg, bpt_ctrl, bpt_dp (bpt_ram below it)
//
//  channel  signals                          payload
//  in       in_valid / in_ready              bpt_pkg::in_beat_t
//  out      out_valid / out_ready            bpt_pkg::out_beat_t
//  cfg      cfg_we (no wait)                 table_points, 7 bits
//
//  one item at a time; a load or an early error goes straight to the result
//  the walk does one ram read for each breakpoint visited
//  raw to eng adds the multiply; eng to raw adds the bit serial divider
//  a new beat is taken while the last result still waits on out_ready
//  reset is synchronous; table contents are undefined until loaded
`timescale 1ns / 1ps

module breakpoint_table_convert #(
  parameter int MAX_POINTS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [bpt_pkg::TP_W-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  bpt_pkg::in_beat_t        in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output bpt_pkg::out_beat_t       out_data
);

  bpt_pkg::ctl_cmd_t cmd;
  bpt_pkg::dp_stat_t stat;

  bpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpt_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ----- rtl/bpt_checker.sv -----
// port level checks for breakpoint_table_convert, bound to the top level
// depends on bpt_pkg
`timescale 1ns / 1ps

module bpt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input bpt_pkg::out_beat_t out_data
);

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed");

  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind breakpoint_table_convert bpt_checker u_bpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
